/* rtl/prff_pkg.sv */
// Package for the page run first-fit finder: sizes, action and state codes,
// item structs and the control group of the run unit. No dependencies.
`timescale 1ns / 1ps

package prff_pkg;

  localparam int PAGES     = 4096;
  localparam int PAGE_BITS = 12;
  localparam int PAGE_W    = $clog2(PAGES);
  localparam int COUNT_W   = PAGE_W + 1;
  localparam int ADDR_W    = 24;
  localparam int FLAG_W    = 3;

  localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(PAGES - 1);

  // flag bits of one page entry
  localparam int FLAG_IN_RAM   = 0;
  localparam int FLAG_MAPPED   = 1;
  localparam int FLAG_RESERVED = 2;

  localparam logic [FLAG_W-1:0] FLAGS_RESERVED_ONLY = FLAG_W'(1 << FLAG_RESERVED);

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_RESERVE = 2'd1,
    ACT_FIND    = 2'd2,
    ACT_CHECK   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_SCAN,
    ST_CHECK
  } state_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [11:0]        start_page;
    logic [12:0]        page_count;
    logic               may_remap;
    logic [2:0]         new_flags;
    logic [ADDR_W-1:0]  address;
  } cmd_t;

  typedef struct packed {
    logic        found;
    logic [11:0] run_start;
  } rsp_t;

  typedef struct packed {
    logic               load;
    logic               step;
    logic               remap;
    logic [COUNT_W-1:0] need;
  } run_ctl_t;

endpackage

/* rtl/prff_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module prff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/prff_run_unit.sv */
// Run unit: tests one page entry per step for being free and tracks the
// length and first page of the current free run. Depends on prff_pkg.
`timescale 1ns / 1ps

module prff_run_unit (
  input  logic                            clk,
  input  prff_pkg::run_ctl_t              ctl,
  input  logic [prff_pkg::FLAG_W-1:0]     flags,
  input  logic [prff_pkg::PAGE_W-1:0]     page,
  output logic                            hit,
  output logic [prff_pkg::PAGE_W-1:0]     run_start
);

  logic [prff_pkg::COUNT_W-1:0] run_len;
  logic [prff_pkg::COUNT_W-1:0] run_len_inc;
  logic [prff_pkg::PAGE_W-1:0]  run_first;
  logic                         free;

  always_comb begin
    free = ((flags[prff_pkg::FLAG_IN_RAM] | flags[prff_pkg::FLAG_MAPPED]) == 1'b0) ||
           (ctl.remap && flags[prff_pkg::FLAG_MAPPED]);
    run_len_inc = run_len + 1'b1;
    hit         = ctl.step && free && (run_len_inc >= ctl.need);
    run_start   = (run_len == '0) ? page : run_first;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      run_len <= '0;
    end else if (ctl.step) begin
      // a blocking page ends the run; the scan simply goes on past it
      run_len <= free ? run_len_inc : '0;
      if (free && run_len == '0) begin
        run_first <= page;
      end
    end
  end

endmodule

/* rtl/page_run_first_fit_finder_unit.sv */
// Top level of the page run first-fit finder: sequencer, page flag RAM and
// run unit. Depends on prff_pkg, prff_ram and prff_run_unit.
//
//  channel  | handshake         | payload          | notes
//  ---------+-------------------+------------------+--------------------------
//  command  | start, busy       | cmd    (cmd_t)   | taken when start && !busy
//  result   | done              | result (rsp_t)   | one cycle, cannot stall
//
// Reset clears the 4096-entry flag RAM, one entry a cycle; busy is high until
// the clear is done. A write and a reserve of zero pages finish on accept; a
// check answers in ST_CHECK from the entry read on accept; a reserve writes
// its pages in ST_FILL, cut at the last page. A search reads one page entry
// per cycle through the single RAM read port up to the first hit or the last
// page. One item at a time; the strobe done may coincide with the next accept.
`timescale 1ns / 1ps

module page_run_first_fit_finder_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  prff_pkg::cmd_t  cmd,
  output logic            done,
  output prff_pkg::rsp_t  result
);

  prff_pkg::state_t state;
  prff_pkg::state_t state_next;

  logic [prff_pkg::PAGE_W-1:0]  clr_page;
  logic [prff_pkg::PAGE_W-1:0]  fill_page;
  logic [prff_pkg::COUNT_W-1:0] fill_left;
  logic [prff_pkg::PAGE_W-1:0]  scan_page;
  logic [prff_pkg::COUNT_W-1:0] need;
  logic                         remap;
  logic                         check_ok;

  logic                          accept;
  logic                          finish;
  logic [prff_pkg::PAGE_W-1:0]   check_page;
  logic                          check_in_range;

  logic                          ram_we;
  logic [prff_pkg::PAGE_W-1:0]   ram_waddr;
  logic [prff_pkg::FLAG_W-1:0]   ram_wdata;
  logic [prff_pkg::PAGE_W-1:0]   ram_raddr;
  logic [prff_pkg::FLAG_W-1:0]   ram_rdata;

  prff_pkg::run_ctl_t            run_ctl;
  logic                          run_hit;
  logic [prff_pkg::PAGE_W-1:0]   run_start;

  function automatic logic [prff_pkg::PAGE_W-1:0] page_inc(
    input logic [prff_pkg::PAGE_W-1:0] p
  );
    return p + 1'b1;
  endfunction

  assign accept         = start && !busy;
  assign check_page     = cmd.address[prff_pkg::ADDR_W-1:prff_pkg::PAGE_BITS];
  assign check_in_range = {1'b0, check_page} < prff_pkg::COUNT_W'(prff_pkg::PAGES);

  prff_ram #(
    .WIDTH(prff_pkg::FLAG_W),
    .DEPTH(prff_pkg::PAGES)
  ) u_flags (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  prff_run_unit u_run (
    .clk      (clk),
    .ctl      (run_ctl),
    .flags    (ram_rdata),
    .page     (scan_page),
    .hit      (run_hit),
    .run_start(run_start)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      prff_pkg::ST_CLEAR: begin
        if (clr_page == prff_pkg::LAST_PAGE) begin
          state_next = prff_pkg::ST_IDLE;
        end
      end
      prff_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd.action)
            prff_pkg::ACT_RESERVE: begin
              if (cmd.page_count != '0) begin
                state_next = prff_pkg::ST_FILL;
              end
            end
            prff_pkg::ACT_FIND:  state_next = prff_pkg::ST_SCAN;
            prff_pkg::ACT_CHECK: state_next = prff_pkg::ST_CHECK;
            default:             state_next = prff_pkg::ST_IDLE;
          endcase
        end
      end
      prff_pkg::ST_FILL: begin
        if (fill_left == prff_pkg::COUNT_W'(1) || fill_page == prff_pkg::LAST_PAGE) begin
          state_next = prff_pkg::ST_IDLE;
        end
      end
      prff_pkg::ST_SCAN: begin
        if (run_hit || scan_page == prff_pkg::LAST_PAGE) begin
          state_next = prff_pkg::ST_IDLE;
        end
      end
      prff_pkg::ST_CHECK: state_next = prff_pkg::ST_IDLE;
      default:            state_next = prff_pkg::ST_CLEAR;
    endcase
  end

  // outputs to the RAM and the run unit
  always_comb begin
    busy          = 1'b1;
    finish        = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = fill_page;
    ram_wdata     = prff_pkg::FLAGS_RESERVED_ONLY;
    ram_raddr     = page_inc(scan_page);
    run_ctl.load  = 1'b0;
    run_ctl.step  = 1'b0;
    run_ctl.remap = remap;
    run_ctl.need  = need;
    case (state)
      prff_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_page;
        ram_wdata = '0;
      end
      prff_pkg::ST_IDLE: begin
        busy         = 1'b0;
        run_ctl.load = 1'b1;
        // present the first read now so its data is there on entry
        ram_raddr    = (cmd.action == prff_pkg::ACT_FIND) ? cmd.start_page : check_page;
        if (accept && cmd.action == prff_pkg::ACT_WRITE) begin
          ram_we    = 1'b1;
          ram_waddr = cmd.start_page;
          ram_wdata = cmd.new_flags;
        end
        finish = accept && (cmd.action == prff_pkg::ACT_WRITE ||
                 (cmd.action == prff_pkg::ACT_RESERVE && cmd.page_count == '0));
      end
      prff_pkg::ST_FILL: begin
        ram_we = 1'b1;
        finish = (state_next == prff_pkg::ST_IDLE);
      end
      prff_pkg::ST_SCAN: begin
        run_ctl.step = 1'b1;
        finish       = (state_next == prff_pkg::ST_IDLE);
      end
      prff_pkg::ST_CHECK: finish = 1'b1;
      default:            busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= prff_pkg::ST_CLEAR;
      clr_page <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
      if (state == prff_pkg::ST_CLEAR) begin
        clr_page <= clr_page + 1'b1;
      end
    end
  end

  // item registers and result
  always_ff @(posedge clk) begin
    if (state == prff_pkg::ST_IDLE && accept) begin
      fill_page <= cmd.start_page;
      fill_left <= cmd.page_count;
      scan_page <= cmd.start_page;
      need      <= (cmd.page_count == '0) ? prff_pkg::COUNT_W'(1) : cmd.page_count;
      remap     <= cmd.may_remap;
      check_ok  <= check_in_range;
    end else if (state == prff_pkg::ST_FILL) begin
      fill_page <= fill_page + 1'b1;
      fill_left <= fill_left - 1'b1;
    end else if (state == prff_pkg::ST_SCAN) begin
      scan_page <= scan_page + 1'b1;
    end

    if (finish) begin
      case (state)
        prff_pkg::ST_SCAN: begin
          result.found     <= run_hit;
          result.run_start <= run_hit ? run_start : '0;
        end
        prff_pkg::ST_CHECK: begin
          result.found     <= check_ok && ram_rdata[prff_pkg::FLAG_IN_RAM];
          result.run_start <= '0;
        end
        default: begin
          result.found     <= 1'b0;
          result.run_start <= '0;
        end
      endcase
    end
  end

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == prff_pkg::ST_CLEAR |-> !done)
    else $error("result strobe during RAM clear");

  a_miss_has_zero_start: assert property (@(posedge clk) disable iff (rst)
    done && !result.found |-> result.run_start == '0)
    else $error("run start set on a miss");

  a_scan_advances: assert property (@(posedge clk) disable iff (rst)
    state == prff_pkg::ST_SCAN && $past(state) == prff_pkg::ST_SCAN |->
    scan_page == prff_pkg::PAGE_W'($past(scan_page) + 1'b1))
    else $error("scan skipped or repeated a page");

  a_long_item_no_strobe: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> !done)
    else $error("result strobe as a multi-cycle item starts");

endmodule

/* sim/tb_page_run_first_fit_finder_unit.sv */
// Self-checking testbench for page_run_first_fit_finder_unit: directed and random
// items are checked against a behavioral page table kept in the bench.
// Depends on prff_pkg and the page_run_first_fit_finder_unit RTL.
`timescale 1ns / 1ps

module tb_page_run_first_fit_finder_unit;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  prff_pkg::cmd_t cmd;
  logic done;
  prff_pkg::rsp_t result;

  page_run_first_fit_finder_unit u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result)
  );

  always #1 clk = ~clk;

  // bench copy of the page flag table and the results still owed by the block
  logic [prff_pkg::FLAG_W-1:0] page_flags_model [prff_pkg::PAGES];
  prff_pkg::rsp_t pending_results [$];

  int sender_idle_pct = 0;
  int mismatches = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int n_writes = 0;
  int n_reserves = 0;
  int n_searches = 0;
  int n_checks = 0;
  int n_hits = 0;

  function automatic bit page_free(int page, bit remap);
    logic [prff_pkg::FLAG_W-1:0] f;
    if (page >= prff_pkg::PAGES) return 1'b0;
    f = page_flags_model[page];
    if (!f[prff_pkg::FLAG_IN_RAM] && !f[prff_pkg::FLAG_MAPPED]) return 1'b1;
    return remap && f[prff_pkg::FLAG_MAPPED];
  endfunction

  function automatic bit first_free_run(int from, int need, bit remap, output int at);
    int i;
    int j;
    bit ok;
    i = from;
    at = 0;
    while (i < prff_pkg::PAGES) begin
      if (page_free(i, remap)) begin
        ok = 1'b1;
        for (j = 1; j < need; j++) begin
          if (!page_free(i + j, remap)) begin
            ok = 1'b0;
            break;
          end
        end
        if (ok) begin
          at = i;
          return 1'b1;
        end
        // skip past the blocking page
        i += j;
      end
      i++;
    end
    return 1'b0;
  endfunction

  // apply one item to the page table and return the result it causes
  function automatic prff_pkg::rsp_t page_table_outcome(prff_pkg::cmd_t c);
    prff_pkg::rsp_t r;
    int p;
    int at;
    r = '0;
    case (prff_pkg::action_t'(c.action))
      prff_pkg::ACT_WRITE: begin
        page_flags_model[c.start_page] = c.new_flags;
      end
      prff_pkg::ACT_RESERVE: begin
        for (int k = 0; k < int'(c.page_count); k++) begin
          p = int'(c.start_page) + k;
          if (p >= prff_pkg::PAGES) break;
          page_flags_model[p] = prff_pkg::FLAGS_RESERVED_ONLY;
        end
      end
      prff_pkg::ACT_FIND: begin
        if (first_free_run(int'(c.start_page), int'(c.page_count), c.may_remap, at)) begin
          r.found = 1'b1;
          r.run_start = 12'(at);
        end
      end
      default: begin
        p = int'(c.address >> prff_pkg::PAGE_BITS);
        r.found = (p < prff_pkg::PAGES) && page_flags_model[p][prff_pkg::FLAG_IN_RAM];
      end
    endcase
    return r;
  endfunction

  function automatic prff_pkg::cmd_t make_cmd(prff_pkg::action_t act, int page, int count,
                                              bit remap, int flags, int addr);
    prff_pkg::cmd_t c;
    c.action = act;
    c.start_page = 12'(page);
    c.page_count = 13'(count);
    c.may_remap = remap;
    c.new_flags = 3'(flags);
    c.address = 24'(addr);
    return c;
  endfunction

  // send one item; start stays high afterwards so back-to-back items need no toggle
  task automatic issue_cmd(prff_pkg::cmd_t c);
    bit idled;
    idled = 1'b0;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      if (!idled) start <= 1'b0;
      idled = 1'b1;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(page_table_outcome(c));
    case (prff_pkg::action_t'(c.action))
      prff_pkg::ACT_WRITE:   n_writes++;
      prff_pkg::ACT_RESERVE: n_reserves++;
      prff_pkg::ACT_FIND:    n_searches++;
      default:               n_checks++;
    endcase
  endtask

  task automatic report_mismatch(string what, int exp_v, int got_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch in %s at result %0d: expected %0d, got %0d",
               what, results_seen, exp_v, got_v);
  endtask

  always @(posedge clk) begin
    prff_pkg::rsp_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result (found)", 0, result.found);
      end else begin
        exp_r = pending_results.pop_front();
        if (result.found !== exp_r.found)
          report_mismatch("found", exp_r.found, result.found);
        if (result.run_start !== exp_r.run_start)
          report_mismatch("run_start", exp_r.run_start, result.run_start);
        if (result.found === 1'b1) n_hits++;
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_search_on_clear_table();
    issue_cmd(make_cmd(prff_pkg::ACT_FIND, 0, 0, 1'b0, 0, 0));
    issue_cmd(make_cmd(prff_pkg::ACT_FIND, 4095, 1, 1'b0, 0, 0));
    // a run that would cross the last page must fail
    issue_cmd(make_cmd(prff_pkg::ACT_FIND, 4095, 2, 1'b1, 0, 0));
    issue_cmd(make_cmd(prff_pkg::ACT_CHECK, 0, 0, 1'b0, 0, 24'h000000));
  endtask

  task automatic test_flag_write_and_check();
    issue_cmd(make_cmd(prff_pkg::ACT_WRITE, 0, 0, 1'b0, 1, 0));
    issue_cmd(make_cmd(prff_pkg::ACT_WRITE, 4095, 0, 1'b0, 7, 0));
    issue_cmd(make_cmd(prff_pkg::ACT_WRITE, 5, 0, 1'b0, 2, 0));
    issue_cmd(make_cmd(prff_pkg::ACT_CHECK, 0, 0, 1'b0, 0, 24'h000ABC));
    issue_cmd(make_cmd(prff_pkg::ACT_CHECK, 0, 0, 1'b0, 0, 24'hFFFFFF));
    issue_cmd(make_cmd(prff_pkg::ACT_CHECK, 0, 0, 1'b0, 0, 24'h005000));
  endtask

  task automatic test_search_rules();
    issue_cmd(make_cmd(prff_pkg::ACT_FIND, 0, 1, 1'b0, 0, 0));
    // mapped page blocks without remap, counts as free with it
    issue_cmd(make_cmd(prff_pkg::ACT_FIND, 0, 5, 1'b0, 0, 0));
    issue_cmd(make_cmd(prff_pkg::ACT_FIND, 0, 5, 1'b1, 0, 0));
    issue_cmd(make_cmd(prff_pkg::ACT_FIND, 4094, 2, 1'b1, 0, 0));
    issue_cmd(make_cmd(prff_pkg::ACT_FIND, 4094, 2, 1'b0, 0, 0));
    issue_cmd(make_cmd(prff_pkg::ACT_FIND, 4095, 1, 1'b0, 0, 0));
    issue_cmd(make_cmd(prff_pkg::ACT_FIND, 4090, 8, 1'b1, 0, 0));
    issue_cmd(make_cmd(prff_pkg::ACT_FIND, 0, 4096, 1'b1, 0, 0));
    issue_cmd(make_cmd(prff_pkg::ACT_FIND, 100, 0, 1'b0, 0, 0));
  endtask

  task automatic test_reserve();
    issue_cmd(make_cmd(prff_pkg::ACT_RESERVE, 0, 0, 1'b0, 0, 0));
    // clip at the last page
    issue_cmd(make_cmd(prff_pkg::ACT_RESERVE, 4090, 4096, 1'b0, 0, 0));
    issue_cmd(make_cmd(prff_pkg::ACT_FIND, 4090, 6, 1'b0, 0, 0));
    issue_cmd(make_cmd(prff_pkg::ACT_CHECK, 0, 0, 1'b0, 0, 24'hFFF000));
    issue_cmd(make_cmd(prff_pkg::ACT_RESERVE, 0, 4096, 1'b0, 0, 0));
    issue_cmd(make_cmd(prff_pkg::ACT_FIND, 0, 4096, 1'b0, 0, 0));
    issue_cmd(make_cmd(prff_pkg::ACT_WRITE, 2048, 0, 1'b0, 3, 0));
    issue_cmd(make_cmd(prff_pkg::ACT_FIND, 0, 4096, 1'b1, 0, 0));
  endtask

  // mostly small counts aimed at a busy low window of pages, some full-range items
  function automatic prff_pkg::cmd_t random_cmd();
    prff_pkg::cmd_t c;
    int roll;
    int pick;
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    c.may_remap = 1'($urandom_range(0, 1));
    c.new_flags = 3'($urandom_range(0, 7));
    c.start_page = ($urandom_range(0, 99) < 70) ? 12'($urandom_range(0, 63))
                                                 : 12'($urandom_range(0, 4095));
    c.address = 24'($urandom);
    c.page_count = 13'($urandom_range(0, 8));
    if (roll < 35) begin
      c.action = prff_pkg::ACT_WRITE;
    end else if (roll < 45) begin
      c.action = prff_pkg::ACT_RESERVE;
      c.page_count = (pick < 90) ? 13'($urandom_range(0, 16)) : 13'($urandom_range(0, 4096));
    end else if (roll < 80) begin
      c.action = prff_pkg::ACT_FIND;
      if (pick >= 97) c.page_count = 13'(4096);
      else if (pick >= 80) c.page_count = 13'($urandom_range(0, 64));
    end else begin
      c.action = prff_pkg::ACT_CHECK;
      if (pick < 60) c.address = {12'($urandom_range(0, 63)), 12'($urandom)};
    end
    return c;
  endfunction

  task automatic test_random_traffic(int idle_pct, int n_items);
    sender_idle_pct = idle_pct;
    repeat (n_items) issue_cmd(random_cmd());
    sender_idle_pct = 0;
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= '0;
    foreach (page_flags_model[i]) page_flags_model[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_search_on_clear_table();
    test_flag_write_and_check();
    test_search_rules();
    test_reserve();
    test_random_traffic(0, 38);
    test_random_traffic(50, 38);
    test_random_traffic(36, 38);
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d writes, %0d reserves, %0d searches and %0d checks; %0d hits",
             n_writes, n_reserves, n_searches, n_checks, n_hits);
    $display("%0d results checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/prff_pkg.sv
rtl/prff_ram.sv
rtl/prff_run_unit.sv
rtl/page_run_first_fit_finder_unit.sv
sim/tb_page_run_first_fit_finder_unit.sv
